>>> rtl/charset_bom_utf8_detector_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the charset BOM / UTF-8 detector
// Clocked implication checks with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef CHARSET_BOM_UTF8_DETECTOR_UNIT_MACROS_SVH
`define CHARSET_BOM_UTF8_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define CBU_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("detector check failed");

// next-cycle implication
`define CBU_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("detector check failed");

`endif

>>> rtl/cbu_pkg.sv
// ----------------------------------------------------------------------------
// cbu_pkg
// Types and codes shared by the charset BOM / UTF-8 detector.
// ----------------------------------------------------------------------------
`default_nettype none

package cbu_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_end;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  charset_code;
        logic [31:0] rune_count;
    } out_item_t;

    localparam logic [3:0] CS_UNKNOWN = 4'd0;
    localparam logic [3:0] CS_ASCII   = 4'd1;
    localparam logic [3:0] CS_UTF7    = 4'd2;
    localparam logic [3:0] CS_UTF8    = 4'd3;
    localparam logic [3:0] CS_UTF8BOM = 4'd4;
    localparam logic [3:0] CS_UTF16BE = 4'd5;
    localparam logic [3:0] CS_UTF16LE = 4'd6;
    localparam logic [3:0] CS_UTF32BE = 4'd7;
    localparam logic [3:0] CS_UTF32LE = 4'd8;

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_UTF8   = 2'd1;
    localparam logic [1:0] PH_STOP   = 2'd2;

    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;

    typedef struct packed {
        logic [3:0][7:0] head;
        logic [2:0]      fill;
        logic [1:0]      total;
        logic [1:0]      phase;
        logic [1:0]      cont;
        logic [20:0]     pend;
        logic            four;
        logic            consumed;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        head:     '0,
        fill:     3'd0,
        total:    2'd0,
        phase:    PH_PREFIX,
        cont:     2'd0,
        pend:     21'd0,
        four:     1'b0,
        consumed: 1'b1
    };

endpackage

`default_nettype wire

>>> rtl/charset_bom_utf8_detector_unit.sv
// ----------------------------------------------------------------------------
// charset_bom_utf8_detector_unit
// Streams a buffer one byte per item and returns one charset verdict and a
// saturating rune count when the buffer closes.
// ----------------------------------------------------------------------------
// Takes one byte item every cycle while byte_stall is low. The scan state
// updates in the same cycle a byte is accepted, and the verdict for a closing
// item (last_byte or empty_end) is written to the output register at that
// edge, so it is offered in the next cycle. Every item, final or not, is
// stalled while a held verdict is itself stalled; otherwise no item waits,
// and the next buffer may begin in the cycle after a close.
`default_nettype none

module charset_bom_utf8_detector_unit #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  cbu_pkg::in_item_t      byte_item,
    output logic                   verdict_valid,
    input  wire logic              verdict_stall,
    output cbu_pkg::out_item_t     verdict_item
);
    import cbu_pkg::*;

    localparam int OutBits = (COUNT_BITS < 32) ? COUNT_BITS : 32;

    scan_state_t           state_reg;
    scan_state_t           state_next;
    scan_state_t           stepped;
    scan_state_t           taken;
    logic [COUNT_BITS-1:0] runes_reg;
    logic [COUNT_BITS-1:0] runes_next;
    logic [COUNT_BITS-1:0] runes_taken;
    logic                  add_rune;
    logic                  add_eff;
    logic                  accept;
    logic                  closing;
    logic [3:0]            code;
    logic                  keep_runes;
    logic                  valid_reg;
    out_item_t             item_reg;

    cbu_step u_step (
        .cur       (state_reg),
        .data_byte (byte_item.data_byte),
        .nxt       (stepped),
        .add_rune  (add_rune)
    );

    assign taken   = byte_item.empty_end ? state_reg : stepped;
    assign add_eff = !byte_item.empty_end && add_rune;
    assign runes_taken = (add_eff && runes_reg != {COUNT_BITS{1'b1}})
                         ? runes_reg + COUNT_BITS'(1) : runes_reg;

    cbu_verdict u_verdict (
        .st           (taken),
        .charset_code (code),
        .keep_runes   (keep_runes)
    );

    assign byte_stall    = valid_reg && verdict_stall;
    assign accept        = byte_valid && !byte_stall;
    assign closing       = byte_item.empty_end || byte_item.last_byte;
    assign verdict_valid = valid_reg;
    assign verdict_item  = item_reg;

    always_comb
    begin
        state_next = state_reg;
        runes_next = runes_reg;
        if (accept)
        begin
            if (closing)
            begin
                state_next = SCAN_RESET;
                runes_next = '0;
            end
            else
            begin
                state_next = taken;
                runes_next = runes_taken;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
            runes_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            runes_reg <= runes_next;
            if (accept && closing)
                valid_reg <= 1'b1;
            else if (!verdict_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && closing)
        begin
            item_reg.charset_code <= code;
            item_reg.rune_count   <= keep_runes ? 32'(runes_taken[OutBits-1:0]) : 32'd0;
        end
    end

`include "charset_bom_utf8_detector_unit_macros.svh"

    `CBU_ASSERT_NEXT(a_close_gives_verdict, clk, rst_n, accept && closing, valid_reg)
    `CBU_ASSERT_NEXT(a_close_clears_scan, clk, rst_n, accept && closing,
        state_reg.fill == 3'd0 && runes_reg == '0)
    `CBU_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, state_reg.fill <= 3'd4)
    `CBU_ASSERT_NOW(a_sig_no_runes, clk, rst_n,
        valid_reg && item_reg.charset_code != CS_UNKNOWN
        && item_reg.charset_code != CS_ASCII && item_reg.charset_code != CS_UTF8,
        item_reg.rune_count == 32'd0)

endmodule

`default_nettype wire

>>> rtl/cbu_step.sv
// ----------------------------------------------------------------------------
// cbu_step
// Scan state update for one buffer byte: head capture, printable prefix
// scan and UTF-8 sequence decoding.
// ----------------------------------------------------------------------------
`default_nettype none

module cbu_step (
    input  cbu_pkg::scan_state_t cur,
    input  logic [7:0]           data_byte,
    output cbu_pkg::scan_state_t nxt,
    output logic                 add_rune
);
    import cbu_pkg::*;

    logic [20:0] shifted;
    logic        utf8_now;

    always_comb
    begin
        nxt      = cur;
        add_rune = 1'b0;
        utf8_now = 1'b0;
        shifted  = {cur.pend[14:0], data_byte[5:0]};

        if (cur.fill != 3'd4)
        begin
            nxt.head[cur.fill[1:0]] = data_byte;
            nxt.fill                = cur.fill + 3'd1;
        end
        nxt.total = cur.total + 2'd1;

        if (cur.phase == PH_PREFIX)
        begin
            if (data_byte inside {[8'h09:8'h0D], [8'h20:8'h7E]})
            begin
                add_rune = 1'b1;
            end
            else
            begin
                nxt.phase = PH_UTF8;
                utf8_now  = 1'b1;
            end
        end
        else if (cur.phase == PH_UTF8)
        begin
            utf8_now = 1'b1;
        end

        if (utf8_now)
        begin
            if (cur.cont != 2'd0)
            begin
                if (data_byte[7:6] != 2'b10)
                begin
                    nxt.phase = PH_STOP;
                end
                else
                begin
                    nxt.pend = shifted;
                    nxt.cont = cur.cont - 2'd1;
                    if (cur.cont == 2'd1)
                    begin
                        if (cur.four && shifted >= SURR_LO && shifted <= SURR_HI)
                            nxt.phase = PH_STOP;
                        else
                            add_rune = 1'b1;
                    end
                end
            end
            else if (data_byte[7] == 1'b0)
            begin
                add_rune = 1'b1;
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                nxt.cont = 2'd1;
                nxt.pend = {16'd0, data_byte[4:0]};
                nxt.four = 1'b0;
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                nxt.cont = 2'd2;
                nxt.pend = {17'd0, data_byte[3:0]};
                nxt.four = 1'b0;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                nxt.cont = 2'd3;
                nxt.pend = {18'd0, data_byte[2:0]};
                nxt.four = 1'b1;
            end
            else
            begin
                nxt.consumed = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/cbu_verdict.sv
// ----------------------------------------------------------------------------
// cbu_verdict
// Final charset verdict from the scan state: signature match in priority
// order, then printable prefix and UTF-8 tail results.
// ----------------------------------------------------------------------------
`default_nettype none

module cbu_verdict (
    input  cbu_pkg::scan_state_t st,
    output logic [3:0]           charset_code,
    output logic                 keep_runes
);
    import cbu_pkg::*;

    logic [3:0] sig;

    always_comb
    begin
        sig = CS_UNKNOWN;
        if (st.fill == 3'd4 && st.total == 2'd0 && st.head[0] == 8'h00
            && st.head[1] == 8'h00 && st.head[2] == 8'hFE && st.head[3] == 8'hFF)
            sig = CS_UTF32BE;
        else if (st.fill == 3'd4 && st.total == 2'd0 && st.head[0] == 8'hFF
            && st.head[1] == 8'hFE && st.head[2] == 8'h00 && st.head[3] == 8'h00)
            sig = CS_UTF32LE;
        else if (st.fill == 3'd4 && st.head[0] == 8'h2B && st.head[1] == 8'h2F
            && st.head[2] == 8'h76
            && (st.head[3] inside {8'h38, 8'h39, 8'h2B, 8'h2F}))
            sig = CS_UTF7;
        else if (st.fill >= 3'd3 && st.head[0] == 8'hEF && st.head[1] == 8'hBB
            && st.head[2] == 8'hBF)
            sig = CS_UTF8BOM;
        else if (st.fill >= 3'd2 && !st.total[0] && st.head[0] == 8'hFE
            && st.head[1] == 8'hFF)
            sig = CS_UTF16BE;
        else if (st.fill >= 3'd2 && !st.total[0] && st.head[0] == 8'hFF
            && st.head[1] == 8'hFE)
            sig = CS_UTF16LE;

        if (st.fill == 3'd0)
        begin
            charset_code = CS_ASCII;
            keep_runes   = 1'b0;
        end
        else if (sig != CS_UNKNOWN)
        begin
            charset_code = sig;
            keep_runes   = 1'b0;
        end
        else
        begin
            keep_runes = 1'b1;
            if (st.phase == PH_PREFIX)
                charset_code = CS_ASCII;
            else if (st.phase == PH_UTF8 && st.cont == 2'd0 && st.consumed)
                charset_code = CS_UTF8;
            else
                charset_code = CS_UNKNOWN;
        end
    end

endmodule

`default_nettype wire
